// ===== hdl/fltpm_pkg.sv =====
package fltpm_pkg;

  localparam int unsigned ENTRIES_PER_TABLE = 512;
  localparam int unsigned IDX_W             = 9;
  localparam int unsigned ENTRY_W           = 64;
  localparam int unsigned VPAGE_W           = 36;
  localparam int unsigned FRAME_W           = 40;
  localparam int unsigned MUL_STEPS         = 4;

  localparam logic [ENTRY_W-1:0] ADDR_MASK = 64'h000F_FFFF_FFFF_F000;
  localparam logic [ENTRY_W-1:0] PTE_P     = 64'h0000_0000_0000_0001;
  localparam logic [ENTRY_W-1:0] PTE_W     = 64'h0000_0000_0000_0002;

  typedef enum logic {
    OP_MAP   = 1'b0,
    OP_UNMAP = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_MEM    = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_EVAL,
    S_MOD,
    S_LEAF
  } state_e;

  typedef struct packed {
    op_e                  opcode;
    logic [VPAGE_W-1:0]   virt_page;
    logic [FRAME_W-1:0]   phys_frame;
    logic [ENTRY_W-1:0]   leaf_flags;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic                 invalidate;
    logic [VPAGE_W-1:0]   invalidate_page;
  } rsp_t;

endpackage

// ===== hdl/fltpm_ram.sv =====
module fltpm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/four_level_page_table_mapper_top.sv =====
// After reset the block holds busy high while it sweeps the table memory to zero;
// configuration writes are taken at any time. A request is taken when start is high
// and busy is low. A full map walk reads three upper-level entries and writes the leaf
// through the single port of the table memory, with a lookup and an evaluate state per
// level, so the next request can start only after the previous walk is done.
// Failing requests finish earlier. Each upper entry whose address lies outside the pool
// at the current base adds a remainder computation in S_MOD for the frame. The result is
// shown on rsp_o for exactly one cycle with done_o high; the receiver cannot stall it.
module four_level_page_table_mapper_top
  import fltpm_pkg::*;
#(
  parameter int unsigned POOL_FRAMES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  req_t                req_i,
  output logic                done_o,
  output rsp_t                rsp_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [FRAME_W-1:0]  cfg_wdata_i
);

  localparam int unsigned FW    = $clog2(POOL_FRAMES);
  localparam int unsigned NW    = $clog2(POOL_FRAMES + 1);
  localparam int unsigned AW    = FW + IDX_W;
  localparam int unsigned DEPTH = POOL_FRAMES * ENTRIES_PER_TABLE;
  localparam int unsigned RAM_W = ENTRY_W + 1;
  localparam int unsigned HW    = FRAME_W / 2;

  localparam logic [FRAME_W-1:0] RECIP  = FRAME_W'((64'd1 << FRAME_W) / 64'(POOL_FRAMES));
  localparam logic [FW:0]        POOL_W = (FW+1)'(POOL_FRAMES);

  state_e                state_q, state_d;
  req_t                  req_q, req_d;
  logic [1:0]            lvl_q, lvl_d;
  logic [FW-1:0]         frame_q, frame_d;
  logic [NW-1:0]         nf_q, nf_d;
  logic [FRAME_W-1:0]    base_q;
  logic [AW-1:0]         clr_q, clr_d;
  logic [FRAME_W-1:0]    rel_q, rel_d;
  logic [2*FRAME_W-1:0]  acc_q, acc_d;
  logic [3:0]            cnt_q, cnt_d;
  logic                  done_q, done_d;
  rsp_t                  rsp_q, rsp_d;

  logic                ram_we;
  logic [AW-1:0]       ram_addr;
  logic [RAM_W-1:0]    ram_wdata;
  logic [RAM_W-1:0]    ram_rdata;

  fltpm_ram #(
    .Width (RAM_W),
    .Depth (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  logic [IDX_W-1:0]      idx;
  logic                  alloc_now;
  logic [ENTRY_W-1:0]    rd_entry;
  logic [FRAME_W-1:0]    rel;
  logic [FRAME_W-1:0]    new_pfn;
  logic [ENTRY_W-1:0]    mid_entry;
  logic [ENTRY_W-1:0]    leaf_entry;
  logic [HW-1:0]         mul_a;
  logic [HW-1:0]         mul_b;
  logic [2*HW-1:0]       mul_p;
  logic [2*FRAME_W-1:0]  mul_part;
  logic [FW:0]           q_lo;
  logic [FW:0]           rem_raw;
  logic [FW:0]           rem_fix;

  always_comb begin
    unique case (lvl_q)
      2'd0:    idx = req_q.virt_page[35:27];
      2'd1:    idx = req_q.virt_page[26:18];
      2'd2:    idx = req_q.virt_page[17:9];
      default: idx = req_q.virt_page[8:0];
    endcase
  end

  // an entry counts only if its tag matches the frame's allocation state
  assign alloc_now  = NW'(frame_q) < nf_q;
  assign rd_entry   = (ram_rdata[ENTRY_W] == alloc_now) ? ram_rdata[ENTRY_W-1:0] : '0;
  assign rel        = rd_entry[51:12] - base_q;
  assign new_pfn    = base_q + FRAME_W'(nf_q);
  assign mid_entry  = {12'h000, new_pfn, 12'h000} | PTE_P | PTE_W;
  assign leaf_entry = (({12'h000, req_q.phys_frame, 12'h000}) & ADDR_MASK)
                      | req_q.leaf_flags | PTE_P;

  always_comb begin
    mul_a = cnt_q[1] ? rel_q[FRAME_W-1:HW] : rel_q[HW-1:0];
    mul_b = cnt_q[0] ? RECIP[FRAME_W-1:HW] : RECIP[HW-1:0];
    mul_p = (2*HW)'(mul_a) * (2*HW)'(mul_b);
    unique case (cnt_q[1:0])
      2'd0:    mul_part = {FRAME_W'(0), mul_p};
      2'd3:    mul_part = {mul_p, FRAME_W'(0)};
      default: mul_part = {HW'(0), mul_p, HW'(0)};
    endcase
  end

  assign q_lo    = acc_q[FRAME_W +: FW+1];
  assign rem_raw = rel_q[FW:0] - (q_lo * POOL_W);
  assign rem_fix = (rem_raw >= POOL_W) ? rem_raw - POOL_W : rem_raw;

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    lvl_d     = lvl_q;
    frame_d   = frame_q;
    nf_d      = nf_q;
    clr_d     = clr_q;
    rel_d     = rel_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    ram_we    = 1'b0;
    ram_addr  = {frame_q, idx};
    ram_wdata = '0;

    unique case (state_q)
      S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_q;
        clr_d    = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          req_d   = req_i;
          lvl_d   = 2'd0;
          frame_d = '0;
          state_d = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (rd_entry[0]) begin
          if (rel < FRAME_W'(POOL_FRAMES)) begin
            frame_d = rel[FW-1:0];
            lvl_d   = lvl_q + 2'd1;
            state_d = (lvl_q == 2'd2) ? S_LEAF : S_LOOKUP;
          end else begin
            rel_d   = rel;
            acc_d   = '0;
            cnt_d   = '0;
            state_d = S_MOD;
          end
        end else if (req_q.opcode == OP_UNMAP) begin
          done_d  = 1'b1;
          rsp_d   = '{status: ST_NOT_FOUND, invalidate: 1'b0, invalidate_page: '0};
          state_d = S_IDLE;
        end else if (nf_q >= NW'(POOL_FRAMES)) begin
          done_d  = 1'b1;
          rsp_d   = '{status: ST_NO_MEM, invalidate: 1'b0, invalidate_page: '0};
          state_d = S_IDLE;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = {NW'(frame_q) <= nf_q, mid_entry};
          nf_d      = nf_q + NW'(1);
          frame_d   = nf_q[FW-1:0];
          lvl_d     = lvl_q + 2'd1;
          state_d   = (lvl_q == 2'd2) ? S_LEAF : S_LOOKUP;
        end
      end
      S_MOD: begin
        if (cnt_q == 4'(MUL_STEPS)) begin
          frame_d = rem_fix[FW-1:0];
          lvl_d   = lvl_q + 2'd1;
          state_d = (lvl_q == 2'd2) ? S_LEAF : S_LOOKUP;
        end else begin
          acc_d = acc_q + mul_part;
          cnt_d = cnt_q + 4'd1;
        end
      end
      S_LEAF: begin
        ram_we    = 1'b1;
        ram_wdata = {alloc_now, (req_q.opcode == OP_MAP) ? leaf_entry : ENTRY_W'(0)};
        done_d    = 1'b1;
        rsp_d     = '{status: ST_OK, invalidate: 1'b1, invalidate_page: req_q.virt_page};
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      nf_q    <= NW'(1);
      base_q  <= '0;
      clr_q   <= '0;
      done_q  <= 1'b0;
      lvl_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      nf_q    <= nf_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
      lvl_q   <= lvl_d;
      cnt_q   <= cnt_d;
      if (cfg_valid_i) begin
        base_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    frame_q <= frame_d;
    rel_q   <= rel_d;
    acc_q   <= acc_d;
    rsp_q   <= rsp_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign rsp_o       = rsp_q;
  assign cfg_ready_o = 1'b1;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    nf_q <= NW'(POOL_FRAMES) && nf_q != '0)
    else $error("free frame pointer out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.invalidate == (rsp_o.status == ST_OK)))
    else $error("invalidate disagrees with status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> (ram_we && ram_wdata == '0))
    else $error("sweep does not write zero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nf_q != $past(nf_q)) |-> ($past(state_q) == S_EVAL && $past(ram_we)))
    else $error("frame taken without a table write");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOOKUP || state_q == S_EVAL || state_q == S_LEAF)
      |-> (NW'(frame_q) < NW'(POOL_FRAMES)))
    else $error("walk frame outside pool");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == S_LOOKUP && !done_o))
    else $error("accepted request did not start a walk");

endmodule
